// ----- hdl/cdsc_pkg.sv -----
// Shared types, constants and calendar functions for the date/serial converter.
// Used by the core, its add/subtract unit and the port checker.
`timescale 1ns / 1ps
package cdsc_pkg;

    localparam int CDSC_MAX_YEAR  = 9999;
    localparam int CDSC_SERIAL_W  = 22;
    localparam int CDSC_YEAR_W    = 14;
    localparam int CDSC_MONTH_W   = 4;
    localparam int CDSC_DAY_W     = 5;

    localparam logic [CDSC_MONTH_W-1:0] CDSC_FEBRUARY = 4'd2;
    localparam logic [CDSC_MONTH_W-1:0] CDSC_DECEMBER = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_Q400,
        ST_C100,
        ST_Q4,
        ST_Y1,
        ST_MON,
        ST_DAY,
        ST_FIN
    } t_state;

    typedef enum logic {
        ACT_DATE_TO_SERIAL = 1'b0,
        ACT_SERIAL_TO_DATE = 1'b1
    } t_action;

    // Days in all years before year y; elaboration use only.
    function automatic int cdsc_days_before_year(input int y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    // Whether year yy, four-year group sp, century c of a 400-year cycle is leap.
    function automatic logic cdsc_is_leap(input logic [1:0] c, input logic [4:0] sp,
                                          input logic [1:0] yy);
        return (yy == 2'd0) && ((sp != 5'd0) || (c == 2'd0));
    endfunction

    function automatic logic [CDSC_DAY_W-1:0] cdsc_month_days(
        input logic [CDSC_MONTH_W-1:0] mo, input logic leap);
        logic [CDSC_DAY_W-1:0] d;
        case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
            CDSC_FEBRUARY:                             d = leap ? 5'd29 : 5'd28;
            default:                                   d = 5'd0;
        endcase
        return d;
    endfunction

    // Length in days of the span that the current sequencer step moves over.
    function automatic logic [CDSC_SERIAL_W-1:0] cdsc_span_len(
        input t_state st, input logic [1:0] c, input logic [4:0] sp,
        input logic [1:0] yy, input logic [CDSC_MONTH_W-1:0] mo);
        logic                      leap;
        logic [CDSC_SERIAL_W-1:0]  len;
        leap = cdsc_is_leap(c, sp, yy);
        case (st)
            ST_Q400: len = 22'd146097;
            ST_C100: len = (c == 2'd0) ? 22'd36525 : 22'd36524;
            ST_Q4:   len = ((sp == 5'd0) && (c != 2'd0)) ? 22'd1460 : 22'd1461;
            ST_Y1:   len = leap ? 22'd366 : 22'd365;
            ST_MON:  len = {{(CDSC_SERIAL_W-CDSC_DAY_W){1'b0}}, cdsc_month_days(mo, leap)};
            default: len = '0;
        endcase
        return len;
    endfunction

    // Years covered by one step of each year stage.
    function automatic logic [CDSC_YEAR_W-1:0] cdsc_year_incr(input t_state st);
        logic [CDSC_YEAR_W-1:0] inc;
        case (st)
            ST_Q400: inc = 14'd400;
            ST_C100: inc = 14'd100;
            ST_Q4:   inc = 14'd4;
            ST_Y1:   inc = 14'd1;
            default: inc = '0;
        endcase
        return inc;
    endfunction

endpackage

// ----- hdl/calendar_date_serial_convert_core.sv -----
// Top level of the date/serial converter: sequencer, registers and output stage.
// Depends on cdsc_pkg and cdsc_alu.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------------
//  request  | i_valid / o_stall   | i_action i_day i_month i_year i_serial
//  result   | o_valid / i_stall   | o_serial_out o_day_out o_month_out o_year_out o_invalid
//
// One request holds the block between its acceptance and the next one. A rejected
// input goes straight to the finish step; otherwise the sequencer walks 400-, 100-,
// 4- and 1-year spans and then months through one shared 22-bit add/subtract unit,
// one span per cycle, with an exit step after each stage, then a day step and a
// finish step. The result moves into the output register from the finish step.
// o_stall is high from acceptance until the result moves into the output register.
// A finished result waits in the output register under i_stall while the next
// request is taken. Reset is synchronous and active low; it clears control state only.
`timescale 1ns / 1ps
module calendar_date_serial_convert_core
    import cdsc_pkg::*;
#(
    parameter int MAX_YEAR = CDSC_MAX_YEAR
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_action,
    input  logic [CDSC_DAY_W-1:0]    i_day,
    input  logic [CDSC_MONTH_W-1:0]  i_month,
    input  logic [CDSC_YEAR_W-1:0]   i_year,
    input  logic [CDSC_SERIAL_W-1:0] i_serial,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [CDSC_SERIAL_W-1:0] o_serial_out,
    output logic [CDSC_DAY_W-1:0]    o_day_out,
    output logic [CDSC_MONTH_W-1:0]  o_month_out,
    output logic [CDSC_YEAR_W-1:0]   o_year_out,
    output logic                     o_invalid
);

    localparam logic [CDSC_SERIAL_W-1:0] MaxSerial =
        CDSC_SERIAL_W'(cdsc_days_before_year(MAX_YEAR + 1));
    localparam logic [CDSC_YEAR_W-1:0] MaxYearV = CDSC_YEAR_W'(MAX_YEAR);

    t_state                    r_state, n_state;
    logic                      r_dir, n_dir;
    logic [CDSC_SERIAL_W-1:0]  r_n, n_n;
    logic [CDSC_YEAR_W-1:0]    r_yr, n_yr;
    logic [1:0]                r_c, n_c;
    logic [4:0]                r_sp, n_sp;
    logic [1:0]                r_yy, n_yy;
    logic [CDSC_MONTH_W-1:0]   r_mo, n_mo;
    logic [CDSC_MONTH_W-1:0]   r_mtgt, n_mtgt;
    logic [CDSC_DAY_W-1:0]     r_day, n_day;
    logic                      r_inv, n_inv;

    logic                      r_ovalid;
    logic [CDSC_SERIAL_W-1:0]  r_oserial;
    logic [CDSC_DAY_W-1:0]     r_oday;
    logic [CDSC_MONTH_W-1:0]   r_omonth;
    logic [CDSC_YEAR_W-1:0]    r_oyear;
    logic                      r_oinv;

    logic                      w_accept;
    logic                      w_bad_in;
    logic                      w_leap;
    logic [CDSC_YEAR_W-1:0]    w_incr;
    logic [CDSC_SERIAL_W-1:0]  w_alu_b;
    logic [CDSC_SERIAL_W-1:0]  w_alu_res;
    logic                      w_alu_lt;
    logic                      w_step;
    logic                      w_day_bad;
    logic                      w_load_out;

    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid & ~o_stall;
    assign w_leap     = cdsc_is_leap(r_c, r_sp, r_yy);
    assign w_incr     = cdsc_year_incr(r_state);
    assign w_day_bad  = (r_day > cdsc_month_days(r_mo, w_leap));
    assign w_load_out = (r_state == ST_FIN) && (!r_ovalid || !i_stall);

    always_comb begin
        if (i_action == ACT_SERIAL_TO_DATE) begin
            w_bad_in = (i_serial == '0) || (i_serial > MaxSerial);
        end else begin
            w_bad_in = (i_month == '0) || (i_month > CDSC_DECEMBER) ||
                       (i_year > MaxYearV) || (i_day == '0);
        end
    end

    always_comb begin
        if (r_state == ST_DAY) begin
            w_alu_b = {{(CDSC_SERIAL_W-CDSC_DAY_W){1'b0}}, r_day};
        end else begin
            w_alu_b = cdsc_span_len(r_state, r_c, r_sp, r_yy, r_mo);
        end
    end

    cdsc_alu u_alu (
        .i_a   (r_n),
        .i_b   (w_alu_b),
        .i_sub (r_dir),
        .o_res (w_alu_res),
        .o_lt  (w_alu_lt)
    );

    // Whether the current stage takes one more span this cycle. Going from
    // serial to date, the span must fit in the remaining count; going from
    // date to serial, the remaining years or months decide.
    always_comb begin
        case (r_state)
            ST_Q400: w_step = r_dir ? !w_alu_lt : (r_yr >= w_incr);
            ST_C100: w_step = r_dir ? (!w_alu_lt && (r_c != 2'd3)) : (r_yr >= w_incr);
            ST_Q4:   w_step = r_dir ? (!w_alu_lt && (r_sp != 5'd24)) : (r_yr >= w_incr);
            ST_Y1:   w_step = r_dir ? (!w_alu_lt && (r_yy != 2'd3)) : (r_yr >= w_incr);
            ST_MON:  w_step = r_dir ? (!w_alu_lt && (r_mo != CDSC_DECEMBER))
                                    : (r_mo < r_mtgt);
            default: w_step = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_bad_in ? ST_FIN : ST_Q400;
                end
            end
            ST_Q400: if (!w_step) n_state = ST_C100;
            ST_C100: if (!w_step) n_state = ST_Q4;
            ST_Q4:   if (!w_step) n_state = ST_Y1;
            ST_Y1:   if (!w_step) n_state = ST_MON;
            ST_MON:  if (!w_step) n_state = ST_DAY;
            ST_DAY:  n_state = ST_FIN;
            ST_FIN:  if (w_load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb begin
        n_dir  = r_dir;
        n_n    = r_n;
        n_yr   = r_yr;
        n_c    = r_c;
        n_sp   = r_sp;
        n_yy   = r_yy;
        n_mo   = r_mo;
        n_mtgt = r_mtgt;
        n_day  = r_day;
        n_inv  = r_inv;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_dir  = i_action;
                    n_n    = (i_action == ACT_SERIAL_TO_DATE) ? i_serial - 1'b1 : '0;
                    n_yr   = (i_action == ACT_SERIAL_TO_DATE) ? '0 : i_year;
                    n_c    = '0;
                    n_sp   = '0;
                    n_yy   = '0;
                    n_mo   = 4'd1;
                    n_mtgt = i_month;
                    n_day  = i_day;
                    n_inv  = w_bad_in;
                end
            end
            ST_Q400, ST_C100, ST_Q4, ST_Y1: begin
                if (w_step) begin
                    n_n  = w_alu_res;
                    n_yr = r_dir ? r_yr + w_incr : r_yr - w_incr;
                    if (r_state == ST_C100) n_c  = r_c + 2'd1;
                    if (r_state == ST_Q4)   n_sp = r_sp + 5'd1;
                    if (r_state == ST_Y1)   n_yy = r_yy + 2'd1;
                end
            end
            ST_MON: begin
                if (w_step) begin
                    n_n  = w_alu_res;
                    n_mo = r_mo + 4'd1;
                end
            end
            ST_DAY: begin
                // Only the date direction adds the day; the month count is the
                // requested month here, so the day limit can be checked.
                if (r_dir == ACT_DATE_TO_SERIAL) begin
                    if (w_day_bad) begin
                        n_inv = 1'b1;
                    end else begin
                        n_n = w_alu_res;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_dir  <= n_dir;
        r_n    <= n_n;
        r_yr   <= n_yr;
        r_c    <= n_c;
        r_sp   <= n_sp;
        r_yy   <= n_yy;
        r_mo   <= n_mo;
        r_mtgt <= n_mtgt;
        r_day  <= n_day;
        r_inv  <= n_inv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
        if (w_load_out) begin
            r_oinv <= r_inv;
            if (r_inv) begin
                r_oserial <= '0;
                r_oday    <= '0;
                r_omonth  <= '0;
                r_oyear   <= '0;
            end else if (r_dir == ACT_SERIAL_TO_DATE) begin
                r_oserial <= '0;
                r_oday    <= r_n[CDSC_DAY_W-1:0] + 1'b1;
                r_omonth  <= r_mo;
                r_oyear   <= r_yr;
            end else begin
                r_oserial <= r_n;
                r_oday    <= '0;
                r_omonth  <= '0;
                r_oyear   <= '0;
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_serial_out = r_oserial;
    assign o_day_out    = r_oday;
    assign o_month_out  = r_omonth;
    assign o_year_out   = r_oyear;
    assign o_invalid    = r_oinv;

endmodule

// ----- hdl/cdsc_alu.sv -----
// Shared 22-bit add/subtract unit for the day count.
// Depends on cdsc_pkg for the width.
`timescale 1ns / 1ps
module cdsc_alu
    import cdsc_pkg::*;
(
    input  logic [CDSC_SERIAL_W-1:0] i_a,
    input  logic [CDSC_SERIAL_W-1:0] i_b,
    input  logic                     i_sub,
    output logic [CDSC_SERIAL_W-1:0] o_res,
    output logic                     o_lt
);

    logic [CDSC_SERIAL_W:0] w_sum;

    always_comb begin
        if (i_sub) begin
            w_sum = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            w_sum = {1'b0, i_a} + {1'b0, i_b};
        end
    end

    assign o_res = w_sum[CDSC_SERIAL_W-1:0];
    // The borrow out of a subtract means a is below b.
    assign o_lt  = i_sub & w_sum[CDSC_SERIAL_W];

endmodule

// ----- hdl/cdsc_checker.sv -----
// Port-level checks for the date/serial converter, bound to the top level.
// Depends on cdsc_pkg for field widths.
`timescale 1ns / 1ps
module cdsc_checker
    import cdsc_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic [CDSC_SERIAL_W-1:0] o_serial_out,
    input logic [CDSC_DAY_W-1:0]    o_day_out,
    input logic [CDSC_MONTH_W-1:0]  o_month_out,
    input logic [CDSC_YEAR_W-1:0]   o_year_out,
    input logic                     o_invalid
);

    // A result that is being held back must stay offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // A rejected request carries nothing but the flag.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> (o_serial_out == '0) && (o_day_out == '0) &&
                                 (o_month_out == '0) && (o_year_out == '0))
        else $error("invalid result with nonzero fields");

    // A good result fills exactly one direction's fields.
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invalid |-> ((o_serial_out != '0) != (o_month_out != '0)))
        else $error("good result fills both or neither direction");

    // A good date has a real month and day.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invalid && (o_month_out != '0) |->
            (o_month_out <= CDSC_DECEMBER) && (o_day_out != '0) && (o_day_out <= 5'd31))
        else $error("date result out of range");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset left the block busy");

endmodule

bind calendar_date_serial_convert_core cdsc_checker u_cdsc_checker (.*);

// ----- bench/tb_calendar_date_serial_convert_core.sv -----
// Self-checking bench for calendar_date_serial_convert_core: date-to-serial and
// serial-to-date requests under random idling on both channels. Depends on cdsc_pkg.
`timescale 1ns / 1ps
module tb_calendar_date_serial_convert_core
    import cdsc_pkg::*;
();

    localparam int unsigned MAX_YEAR = CDSC_MAX_YEAR;

    typedef struct packed {
        logic [CDSC_SERIAL_W-1:0] serial;
        logic [CDSC_DAY_W-1:0]    day;
        logic [CDSC_MONTH_W-1:0]  month;
        logic [CDSC_YEAR_W-1:0]   year;
        logic                     invalid;
    } t_conv_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_action = 1'b0;
    logic [CDSC_DAY_W-1:0]    i_day = '0;
    logic [CDSC_MONTH_W-1:0]  i_month = '0;
    logic [CDSC_YEAR_W-1:0]   i_year = '0;
    logic [CDSC_SERIAL_W-1:0] i_serial = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [CDSC_SERIAL_W-1:0] o_serial_out;
    logic [CDSC_DAY_W-1:0]    o_day_out;
    logic [CDSC_MONTH_W-1:0]  o_month_out;
    logic [CDSC_YEAR_W-1:0]   o_year_out;
    logic                     o_invalid;

    t_conv_result predicted_conversions[$];
    bit           tx_idle_en = 1'b1;
    bit           rx_stall_en = 1'b1;
    int           rx_hold = 0;
    int           mismatches = 0;
    int           results_checked = 0;
    int           date_requests = 0;
    int           serial_requests = 0;
    int           flagged_results = 0;

    calendar_date_serial_convert_core #(.MAX_YEAR(MAX_YEAR)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_day        (i_day),
        .i_month      (i_month),
        .i_year       (i_year),
        .i_serial     (i_serial),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_serial_out (o_serial_out),
        .o_day_out    (o_day_out),
        .o_month_out  (o_month_out),
        .o_year_out   (o_year_out),
        .o_invalid    (o_invalid)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------- calendar math

    function automatic bit is_leap_year(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned year_days(int unsigned y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    function automatic int unsigned days_before(int unsigned y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    function automatic int unsigned month_length(int unsigned m, int unsigned y);
        int unsigned n;
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11:           n = 30;
            2:                     n = is_leap_year(y) ? 29 : 28;
            default:               n = 0;
        endcase
        return n;
    endfunction

    function automatic t_conv_result convert_calendar(t_action act,
                                                      logic [CDSC_DAY_W-1:0] d,
                                                      logic [CDSC_MONTH_W-1:0] m,
                                                      logic [CDSC_YEAR_W-1:0] y,
                                                      logic [CDSC_SERIAL_W-1:0] s);
        t_conv_result r;
        int unsigned  n;
        int unsigned  yr;
        int unsigned  mo;
        r = '0;
        if (act == ACT_DATE_TO_SERIAL) begin
            if (m < 1 || m > 12 || y > MAX_YEAR || d < 1 || d > month_length(m, y)) begin
                r.invalid = 1'b1;
            end else begin
                n = days_before(y);
                for (mo = 1; mo < m; mo++) n += month_length(mo, y);
                n += d;
                r.serial = n[CDSC_SERIAL_W-1:0];
            end
        end else begin
            if (s < 1 || s > days_before(MAX_YEAR + 1)) begin
                r.invalid = 1'b1;
            end else begin
                // Whole 400-year cycles first, then single years, then months.
                n  = s - 1;
                yr = (n / 146097) * 400;
                n  = n % 146097;
                while (n >= year_days(yr)) begin
                    n -= year_days(yr);
                    yr++;
                end
                mo = 1;
                while (mo < 12 && n >= month_length(mo, yr)) begin
                    n -= month_length(mo, yr);
                    mo++;
                end
                r.day   = CDSC_DAY_W'(n + 1);
                r.month = CDSC_MONTH_W'(mo);
                r.year  = CDSC_YEAR_W'(yr);
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // Mostly zero, often short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 30);
    endfunction

    // A legal date, biased toward leap-rule years and month edges.
    task automatic pick_date(output logic [CDSC_DAY_W-1:0] d,
                             output logic [CDSC_MONTH_W-1:0] m,
                             output logic [CDSC_YEAR_W-1:0] y);
        int unsigned edge_years[12] = '{0, 1, 3, 4, 99, 100, 399, 400, 1900, 2000, 9996, 9999};
        int unsigned yy;
        int unsigned mm;
        int unsigned len;
        yy  = ($urandom_range(0, 9) < 3) ? edge_years[$urandom_range(0, 11)]
                                         : $urandom_range(0, MAX_YEAR);
        mm  = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
        len = month_length(mm, yy);
        case ($urandom_range(0, 4))
            0:       d = CDSC_DAY_W'(len);
            1:       d = 5'd1;
            default: d = CDSC_DAY_W'($urandom_range(1, len));
        endcase
        m = CDSC_MONTH_W'(mm);
        y = CDSC_YEAR_W'(yy);
    endtask

    task automatic send_request(t_action act, logic [CDSC_DAY_W-1:0] d,
                                logic [CDSC_MONTH_W-1:0] m, logic [CDSC_YEAR_W-1:0] y,
                                logic [CDSC_SERIAL_W-1:0] s);
        t_conv_result want;
        int           gap;
        i_action <= act;
        i_day    <= d;
        i_month  <= m;
        i_year   <= y;
        i_serial <= s;
        i_valid  <= 1'b1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        want = convert_calendar(act, d, m, y, s);
        predicted_conversions.push_back(want);
        if (act == ACT_DATE_TO_SERIAL) date_requests++;
        else serial_requests++;
        if (want.invalid) flagged_results++;
        // Valid stays high when the next request follows back to back.
        gap = tx_idle_en ? idle_len() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------- result checker

    always @(posedge i_clk) begin
        t_conv_result got;
        t_conv_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            got = '{o_serial_out, o_day_out, o_month_out, o_year_out, o_invalid};
            if (predicted_conversions.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: %p", got));
            end else begin
                want = predicted_conversions.pop_front();
                results_checked++;
                if (got.serial !== want.serial || got.day !== want.day ||
                    got.month !== want.month || got.year !== want.year ||
                    got.invalid !== want.invalid) begin
                    report_mismatch($sformatf("expected %p, got %p", want, got));
                end
            end
        end
    end

    // Receiver stalls in random stretches whose lengths are drawn from idle_len().
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            i_stall <= rx_stall_en && ($urandom_range(0, 2) == 0);
            rx_hold <= idle_len();
        end else begin
            rx_hold <= rx_hold - 1;
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_date_extremes();
        logic [CDSC_SERIAL_W-1:0] junk;
        junk = '1;
        send_request(ACT_DATE_TO_SERIAL, 5'd1, 4'd1, 14'd0, junk);
        send_request(ACT_DATE_TO_SERIAL, 5'd31, CDSC_DECEMBER, 14'd9999, junk);
        send_request(ACT_DATE_TO_SERIAL, 5'd29, CDSC_FEBRUARY, 14'd0, junk);
        send_request(ACT_DATE_TO_SERIAL, 5'd29, CDSC_FEBRUARY, 14'd2000, junk);
        send_request(ACT_DATE_TO_SERIAL, 5'd29, CDSC_FEBRUARY, 14'd1900, junk);
        send_request(ACT_DATE_TO_SERIAL, 5'd29, CDSC_FEBRUARY, 14'd2023, junk);
        send_request(ACT_DATE_TO_SERIAL, 5'd28, CDSC_FEBRUARY, 14'd2023, junk);
        send_request(ACT_DATE_TO_SERIAL, 5'd31, 4'd4, 14'd2021, junk);
        send_request(ACT_DATE_TO_SERIAL, 5'd30, 4'd4, 14'd2021, junk);
        send_request(ACT_DATE_TO_SERIAL, 5'd0, 4'd6, 14'd500, junk);
        send_request(ACT_DATE_TO_SERIAL, 5'd31, 4'd1, 14'd10000, junk);
        send_request(ACT_DATE_TO_SERIAL, '1, '1, '1, '0);
        send_request(ACT_DATE_TO_SERIAL, 5'd1, 4'd0, 14'd5, junk);
        send_request(ACT_DATE_TO_SERIAL, 5'd1, 4'd13, 14'd5, junk);
    endtask

    task automatic test_serial_extremes();
        int unsigned last;
        last = days_before(MAX_YEAR + 1);
        send_request(ACT_SERIAL_TO_DATE, '1, '1, '1, 22'd0);
        send_request(ACT_SERIAL_TO_DATE, '1, '1, '1, 22'd1);
        send_request(ACT_SERIAL_TO_DATE, '1, '1, '1, 22'd60);
        send_request(ACT_SERIAL_TO_DATE, '1, '1, '1, 22'd366);
        send_request(ACT_SERIAL_TO_DATE, '0, '0, '0, 22'd367);
        send_request(ACT_SERIAL_TO_DATE, '1, '1, '1,
                     CDSC_SERIAL_W'(days_before(2000) + 60));
        send_request(ACT_SERIAL_TO_DATE, '1, '1, '1, CDSC_SERIAL_W'(last));
        send_request(ACT_SERIAL_TO_DATE, '1, '1, '1, CDSC_SERIAL_W'(last + 1));
        send_request(ACT_SERIAL_TO_DATE, '1, '1, '1, '1);
    endtask

    task automatic test_random_dates(int count);
        logic [CDSC_DAY_W-1:0]   d;
        logic [CDSC_MONTH_W-1:0] m;
        logic [CDSC_YEAR_W-1:0]  y;
        repeat (count) begin
            if ($urandom_range(0, 9) < 8) begin
                pick_date(d, m, y);
            end else begin
                d = CDSC_DAY_W'($urandom);
                m = CDSC_MONTH_W'($urandom);
                y = CDSC_YEAR_W'($urandom);
            end
            send_request(ACT_DATE_TO_SERIAL, d, m, y, CDSC_SERIAL_W'($urandom));
        end
    endtask

    task automatic test_random_serials(int count);
        logic [CDSC_DAY_W-1:0]    d;
        logic [CDSC_MONTH_W-1:0]  m;
        logic [CDSC_YEAR_W-1:0]   y;
        logic [CDSC_SERIAL_W-1:0] s;
        t_conv_result             near;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0: s = CDSC_SERIAL_W'($urandom);
                1, 2, 3: s = CDSC_SERIAL_W'($urandom_range(1, days_before(MAX_YEAR + 1)));
                default: begin
                    // Serials near interesting dates, one day either side.
                    pick_date(d, m, y);
                    near = convert_calendar(ACT_DATE_TO_SERIAL, d, m, y, '0);
                    s = near.serial + CDSC_SERIAL_W'($urandom_range(0, 2)) - 1'b1;
                end
            endcase
            send_request(ACT_SERIAL_TO_DATE, CDSC_DAY_W'($urandom), CDSC_MONTH_W'($urandom),
                         CDSC_YEAR_W'($urandom), s);
        end
    endtask

    task automatic test_mixed_traffic(int count);
        int i;
        for (i = 0; i < count; i++) begin
            // The first half runs with no idling on either side.
            tx_idle_en  = (i >= count / 2);
            rx_stall_en = (i >= count / 2);
            if ($urandom_range(0, 1) == 0) test_random_dates(1);
            else test_random_serials(1);
        end
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin
        int waited;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_date_extremes();
        test_serial_extremes();
        test_random_dates(250);
        test_random_serials(250);
        test_mixed_traffic(200);
        i_valid <= 1'b0;

        waited = 0;
        while (predicted_conversions.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (predicted_conversions.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived",
                                      predicted_conversions.size()));
        end

        $display("Sent %0d date-to-serial and %0d serial-to-date requests, %0d of them invalid.",
                 date_requests, serial_requests, flagged_results);
        $display("Checked %0d results; %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/cdsc_pkg.sv
hdl/cdsc_alu.sv
hdl/calendar_date_serial_convert_core.sv
hdl/cdsc_checker.sv
bench/tb_calendar_date_serial_convert_core.sv
